// File: hdl/tun_pkg.sv
// Shared constants for the triangle unit normal pipeline.
`timescale 1ns / 1ps
package tun_pkg;
  localparam int unsigned COORD_WIDTH_DEF   = 24;
  localparam int unsigned OUT_FRAC_BITS_DEF = 16;
endpackage

// File: hdl/tun_cross.sv
// Edge vectors and exact cross product in three register stages.
`timescale 1ns / 1ps
module tun_cross import tun_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int unsigned D = COORD_WIDTH + 1,
  localparam int unsigned N = 2 * D + 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       vld_i,
  input  logic [9*COORD_WIDTH-1:0]   pts_i,
  output logic                       vld_o,
  output logic [3*N-1:0]             n_o
);
  logic [COORD_WIDTH-1:0] c [9];
  logic signed [D-1:0] ext [9];
  logic signed [D-1:0] w_q [3];
  logic signed [D-1:0] v_q [3];
  logic signed [2*D-1:0] p_q [6];
  logic signed [N-1:0] n_q [3];
  logic vld1_q, vld2_q, vld3_q;

  for (genvar k = 0; k < 9; k++) begin : g_ext
    assign c[k]   = pts_i[k*COORD_WIDTH +: COORD_WIDTH];
    assign ext[k] = {c[k][COORD_WIDTH-1], c[k]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        w_q[j] <= ext[j] - ext[j+3];
        v_q[j] <= ext[j+6] - ext[j+3];
      end
      p_q[0] <= (2*D)'(w_q[1]) * (2*D)'(v_q[2]);
      p_q[1] <= (2*D)'(w_q[2]) * (2*D)'(v_q[1]);
      p_q[2] <= (2*D)'(w_q[2]) * (2*D)'(v_q[0]);
      p_q[3] <= (2*D)'(w_q[0]) * (2*D)'(v_q[2]);
      p_q[4] <= (2*D)'(w_q[0]) * (2*D)'(v_q[1]);
      p_q[5] <= (2*D)'(w_q[1]) * (2*D)'(v_q[0]);
      for (int j = 0; j < 3; j++) begin
        n_q[j] <= {p_q[2*j][2*D-1], p_q[2*j]} - {p_q[2*j+1][2*D-1], p_q[2*j+1]};
      end
    end
  end

  assign vld_o = vld3_q;
  assign n_o   = {n_q[2], n_q[1], n_q[0]};
endmodule

// File: hdl/tun_square.sv
// Magnitudes of the normal and their sum of squares from split partial products.
`timescale 1ns / 1ps
module tun_square import tun_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int unsigned D  = COORD_WIDTH + 1,
  localparam int unsigned N  = 2 * D + 1,
  localparam int unsigned M  = 2 * D,
  localparam int unsigned H  = D,
  localparam int unsigned SW = 2 * M + 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [3*N-1:0]   n_i,
  output logic             vld_o,
  output logic [SW-1:0]    sum_o,
  output logic [3*M-1:0]   mag_o,
  output logic [2:0]       neg_o,
  output logic             zero_o
);
  logic [M-1:0] mag_a_q [3];
  logic [M-1:0] mag_b_q [3];
  logic [M-1:0] mag_c_q [3];
  logic [M-1:0] mag_d_q [3];
  logic [2:0] neg_a_q, neg_b_q, neg_c_q, neg_d_q;
  logic zero_a_q, zero_b_q, zero_c_q, zero_d_q;
  logic [2*H-1:0] hh_q [3];
  logic [2*H-1:0] hl_q [3];
  logic [2*H-1:0] ll_q [3];
  logic [SW-1:0] sq_q [3];
  logic [SW-1:0] sum_q;
  logic vld_a_q, vld_b_q, vld_c_q, vld_d_q;
  logic [N-1:0] n_in [3];

  for (genvar j = 0; j < 3; j++) begin : g_in
    assign n_in[j] = n_i[j*N +: N];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
      vld_d_q <= 1'b0;
    end else if (en_i) begin
      vld_a_q <= vld_i;
      vld_b_q <= vld_a_q;
      vld_c_q <= vld_b_q;
      vld_d_q <= vld_c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        mag_a_q[j] <= n_in[j][N-1] ? M'(-n_in[j]) : n_in[j][M-1:0];
        neg_a_q[j] <= n_in[j][N-1];
        hh_q[j] <= (2*H)'(mag_a_q[j][M-1:H]) * (2*H)'(mag_a_q[j][M-1:H]);
        hl_q[j] <= (2*H)'(mag_a_q[j][M-1:H]) * (2*H)'(mag_a_q[j][H-1:0]);
        ll_q[j] <= (2*H)'(mag_a_q[j][H-1:0]) * (2*H)'(mag_a_q[j][H-1:0]);
        sq_q[j] <= (SW'(hh_q[j]) << M) + (SW'(hl_q[j]) << (H + 1)) + SW'(ll_q[j]);
      end
      zero_a_q <= (n_in[0] == '0) && (n_in[1] == '0) && (n_in[2] == '0);
      mag_b_q  <= mag_a_q;
      mag_c_q  <= mag_b_q;
      mag_d_q  <= mag_c_q;
      neg_b_q  <= neg_a_q;
      neg_c_q  <= neg_b_q;
      neg_d_q  <= neg_c_q;
      zero_b_q <= zero_a_q;
      zero_c_q <= zero_b_q;
      zero_d_q <= zero_c_q;
      sum_q    <= sq_q[0] + sq_q[1] + sq_q[2];
    end
  end

  assign vld_o  = vld_d_q;
  assign sum_o  = sum_q;
  assign mag_o  = {mag_d_q[2], mag_d_q[1], mag_d_q[0]};
  assign neg_o  = neg_d_q;
  assign zero_o = zero_d_q;
endmodule

// File: hdl/tun_sqrt.sv
// Integer square root, one result bit per pipeline stage, with a carried side payload.
`timescale 1ns / 1ps
module tun_sqrt import tun_pkg::*; #(
  parameter int unsigned K      = 2 * COORD_WIDTH_DEF + 3,
  parameter int unsigned SIDE_W = 1,
  localparam int unsigned SW = 2 * K,
  localparam int unsigned RW = K + 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [SW-1:0]     rad_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [K-1:0]      root_o,
  output logic [SIDE_W-1:0] side_o
);
  logic [RW-1:0]     rem_q  [K];
  logic [K-1:0]      root_q [K];
  logic [SW-1:0]     rad_q  [K];
  logic [SIDE_W-1:0] side_q [K];
  logic              vld_q  [K];

  for (genvar i = 0; i < K; i++) begin : g_st
    logic [RW-1:0]     rem_in;
    logic [K-1:0]      root_in;
    logic [SW-1:0]     rad_in;
    logic [SIDE_W-1:0] side_in;
    logic              vld_in;
    logic [RW+1:0]     t;
    logic [RW+1:0]     trial;
    logic              ge;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
      assign vld_in  = vld_i;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign rad_in  = rad_q[i-1];
      assign side_in = side_q[i-1];
      assign vld_in  = vld_q[i-1];
    end

    assign t     = {rem_in, rad_in[SW-1 -: 2]};
    assign trial = {{(RW-K){1'b0}}, root_in, 2'b01};
    assign ge    = (t >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= ge ? RW'(t - trial) : t[RW-1:0];
        root_q[i] <= {root_in[K-2:0], ge};
        rad_q[i]  <= {rad_in[SW-3:0], 2'b00};
        side_q[i] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[K-1];
  assign root_o = root_q[K-1];
  assign side_o = side_q[K-1];
endmodule

// File: hdl/tun_div.sv
// Three-lane restoring divider, one quotient bit per pipeline stage.
`timescale 1ns / 1ps
module tun_div import tun_pkg::*; #(
  parameter int unsigned M             = 2 * COORD_WIDTH_DEF + 2,
  parameter int unsigned OUT_FRAC_BITS = OUT_FRAC_BITS_DEF,
  localparam int unsigned K  = M + 1,
  localparam int unsigned Q  = OUT_FRAC_BITS + 2,
  localparam int unsigned XW = M + OUT_FRAC_BITS + 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [K-1:0]     r_i,
  input  logic [3*M-1:0]   mag_i,
  input  logic [2:0]       neg_i,
  input  logic             zero_i,
  output logic             vld_o,
  output logic [3*Q-1:0]   quot_o,
  output logic [2:0]       neg_o,
  output logic             zero_o
);
  logic [XW-1:0] rem_q  [Q][3];
  logic [Q-1:0]  quo_q  [Q][3];
  logic [K-1:0]  r_q    [Q];
  logic [2:0]    neg_q  [Q];
  logic          zero_q [Q];
  logic          vld_q  [Q];

  for (genvar i = 0; i < Q; i++) begin : g_st
    localparam int unsigned B = Q - 1 - i;
    logic [XW-1:0] rem_in [3];
    logic [Q-1:0]  quo_in [3];
    logic [K-1:0]  r_in;
    logic [2:0]    neg_in;
    logic          zero_in;
    logic          vld_in;
    logic [XW-1:0] dvs;

    if (i == 0) begin : g_first
      for (genvar j = 0; j < 3; j++) begin : g_lane
        assign rem_in[j] = XW'(mag_i[j*M +: M]) << OUT_FRAC_BITS;
        assign quo_in[j] = '0;
      end
      assign r_in    = r_i;
      assign neg_in  = neg_i;
      assign zero_in = zero_i;
      assign vld_in  = vld_i;
    end else begin : g_next
      for (genvar j = 0; j < 3; j++) begin : g_lane
        assign rem_in[j] = rem_q[i-1][j];
        assign quo_in[j] = quo_q[i-1][j];
      end
      assign r_in    = r_q[i-1];
      assign neg_in  = neg_q[i-1];
      assign zero_in = zero_q[i-1];
      assign vld_in  = vld_q[i-1];
    end

    assign dvs = XW'(r_in) << B;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int j = 0; j < 3; j++) begin
          if (rem_in[j] >= dvs) begin
            rem_q[i][j] <= rem_in[j] - dvs;
            quo_q[i][j] <= {quo_in[j][Q-2:0], 1'b1};
          end else begin
            rem_q[i][j] <= rem_in[j];
            quo_q[i][j] <= {quo_in[j][Q-2:0], 1'b0};
          end
        end
        r_q[i]    <= r_in;
        neg_q[i]  <= neg_in;
        zero_q[i] <= zero_in;
      end
    end
  end

  assign vld_o  = vld_q[Q-1];
  assign quot_o = {quo_q[Q-1][2], quo_q[Q-1][1], quo_q[Q-1][0]};
  assign neg_o  = neg_q[Q-1];
  assign zero_o = zero_q[Q-1];
endmodule

// File: hdl/triangle_unit_normal_unit.sv
// Top level of the triangle unit normal pipeline.
//
// Slave channel: one beat carries three points p1, p2, p3 as nine signed
// Q16.8 coordinates. Master channel: one beat carries the unit normal -n/|n|
// in signed Q2.16, with tuser flagging a degenerate triangle, for which the
// normal reads (0, 0, 1.0).
// Throughput is one beat per cycle while the output is not stalled. A beat
// passes in order through the cross product, the squared magnitude, the
// square root, the dividers and the output register.
// Reset clears every valid bit; no data is kept from one beat to the next.
// When the receiver holds m_axis_tready low with a beat waiting, the whole
// pipeline freezes and s_axis_tready drops, so no beat is lost or repeated.
`timescale 1ns / 1ps
module triangle_unit_normal_unit import tun_pkg::*; #(
  parameter int unsigned COORD_WIDTH   = COORD_WIDTH_DEF,
  parameter int unsigned OUT_FRAC_BITS = OUT_FRAC_BITS_DEF,
  localparam int unsigned IW = ((9 * COORD_WIDTH + 7) / 8) * 8,
  localparam int unsigned Q  = OUT_FRAC_BITS + 2,
  localparam int unsigned OW = ((3 * Q + 7) / 8) * 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z
  input  logic [IW-1:0] s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // norm_x, norm_y, norm_z
  output logic [OW-1:0] m_axis_tdata,
  // degenerate
  output logic [0:0]    m_axis_tuser
);
  localparam int unsigned D  = COORD_WIDTH + 1;
  localparam int unsigned N  = 2 * D + 1;
  localparam int unsigned M  = 2 * D;
  localparam int unsigned K  = M + 1;
  localparam int unsigned SW = 2 * K;
  localparam int unsigned SIDE_W = 3 * M + 4;

  logic en;
  logic cr_vld, sq_vld, rt_vld, dv_vld;
  logic [3*N-1:0] cr_n;
  logic [SW-1:0] sq_sum;
  logic [3*M-1:0] sq_mag, rt_mag;
  logic [2:0] sq_neg, rt_neg, dv_neg;
  logic sq_zero, rt_zero, dv_zero;
  logic [SIDE_W-1:0] rt_side;
  logic [K-1:0] rt_root;
  logic [3*Q-1:0] dv_quot;
  logic [Q-1:0] norm_d [3];
  logic [Q-1:0] norm_q [3];
  logic degen_q;
  logic out_vld_q;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  tun_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s_axis_tvalid),
    .pts_i  (s_axis_tdata[9*COORD_WIDTH-1:0]),
    .vld_o  (cr_vld),
    .n_o    (cr_n)
  );

  tun_square #(.COORD_WIDTH(COORD_WIDTH)) u_square (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (cr_vld),
    .n_i    (cr_n),
    .vld_o  (sq_vld),
    .sum_o  (sq_sum),
    .mag_o  (sq_mag),
    .neg_o  (sq_neg),
    .zero_o (sq_zero)
  );

  tun_sqrt #(.K(K), .SIDE_W(SIDE_W)) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (sq_vld),
    .rad_i  (sq_sum),
    .side_i ({sq_zero, sq_neg, sq_mag}),
    .vld_o  (rt_vld),
    .root_o (rt_root),
    .side_o (rt_side)
  );

  assign rt_mag  = rt_side[3*M-1:0];
  assign rt_neg  = rt_side[3*M +: 3];
  assign rt_zero = rt_side[SIDE_W-1];

  tun_div #(.M(M), .OUT_FRAC_BITS(OUT_FRAC_BITS)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (rt_vld),
    .r_i    (rt_root),
    .mag_i  (rt_mag),
    .neg_i  (rt_neg),
    .zero_i (rt_zero),
    .vld_o  (dv_vld),
    .quot_o (dv_quot),
    .neg_o  (dv_neg),
    .zero_o (dv_zero)
  );

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      norm_d[j] = dv_neg[j] ? dv_quot[j*Q +: Q] : Q'(-dv_quot[j*Q +: Q]);
    end
    if (dv_zero) begin
      norm_d[0] = '0;
      norm_d[1] = '0;
      norm_d[2] = Q'(1) << OUT_FRAC_BITS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      norm_q  <= norm_d;
      degen_q <= dv_zero;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OW-3*Q){1'b0}}, norm_q[2], norm_q[1], norm_q[0]};
  assign m_axis_tuser  = degen_q;
endmodule

// File: tb/tun_normal_scoreboard.sv
// Scoreboard that predicts and checks the unit normal beats of the pipeline.
`timescale 1ns / 1ps
module tun_normal_scoreboard import tun_pkg::*; #(
  parameter int unsigned CW = COORD_WIDTH_DEF,
  parameter int unsigned FB = OUT_FRAC_BITS_DEF,
  localparam int unsigned IW = ((9 * CW + 7) / 8) * 8,
  localparam int unsigned Q  = FB + 2,
  localparam int unsigned OW = ((3 * Q + 7) / 8) * 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pts_valid_i,
  input  logic          pts_ready_i,
  input  logic [IW-1:0] pts_data_i,
  input  logic          nrm_valid_i,
  input  logic          nrm_ready_i,
  input  logic [OW-1:0] nrm_data_i,
  input  logic [0:0]    nrm_user_i,
  output int            errors_o,
  output int            pending_o
);
  typedef struct packed {
    logic [Q-1:0] nx;
    logic [Q-1:0] ny;
    logic [Q-1:0] nz;
    logic         degen;
  } normal_t;

  normal_t expected_normals[$];

  function automatic normal_t predict_normal(logic [IW-1:0] d);
    logic signed [127:0] c[9];
    logic signed [127:0] w[3];
    logic signed [127:0] v[3];
    logic signed [127:0] n[3];
    logic [191:0] mag[3];
    logic [191:0] sumsq;
    logic [191:0] root;
    logic [191:0] trial;
    logic [191:0] quot;
    logic [Q-1:0] comp[3];
    normal_t res;
    for (int i = 0; i < 9; i++) begin
      c[i] = 128'(signed'(d[i*CW +: CW]));
    end
    for (int i = 0; i < 3; i++) begin
      w[i] = c[i] - c[3+i];
      v[i] = c[6+i] - c[3+i];
    end
    n[0] = w[1] * v[2] - w[2] * v[1];
    n[1] = w[2] * v[0] - w[0] * v[2];
    n[2] = w[0] * v[1] - w[1] * v[0];
    sumsq = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = n[i] < 0 ? 192'(-n[i]) : 192'(n[i]);
      sumsq += mag[i] * mag[i];
    end
    if (sumsq == 0) begin
      res.nx = '0;
      res.ny = '0;
      res.nz = Q'(1) << FB;
      res.degen = 1'b1;
      return res;
    end
    root = '0;
    for (int b = 94; b >= 0; b--) begin
      trial = root | (192'(1) << b);
      if (trial * trial <= sumsq) root = trial;
    end
    for (int i = 0; i < 3; i++) begin
      quot = (mag[i] << FB) / root;
      comp[i] = n[i] < 0 ? Q'(quot) : Q'(-quot);
    end
    res.nx = comp[0];
    res.ny = comp[1];
    res.nz = comp[2];
    res.degen = 1'b0;
    return res;
  endfunction

  assign pending_o = expected_normals.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    normal_t want;
    normal_t got;
    if (!rst_ni) begin
      errors_o <= 0;
    end else begin
      if (pts_valid_i && pts_ready_i) begin
        expected_normals.push_back(predict_normal(pts_data_i));
      end
      if (nrm_valid_i && nrm_ready_i) begin
        got.nx = nrm_data_i[0 +: Q];
        got.ny = nrm_data_i[Q +: Q];
        got.nz = nrm_data_i[2*Q +: Q];
        got.degen = nrm_user_i[0];
        if (expected_normals.size() == 0) begin
          $error("Unexpected output beat: %h", nrm_data_i);
          errors_o <= errors_o + 1;
        end else begin
          want = expected_normals.pop_front();
          if (got.nx !== want.nx) $error("norm_x: expected %h, got %h", want.nx, got.nx);
          if (got.ny !== want.ny) $error("norm_y: expected %h, got %h", want.ny, got.ny);
          if (got.nz !== want.nz) $error("norm_z: expected %h, got %h", want.nz, got.nz);
          if (got.degen !== want.degen) begin
            $error("degenerate: expected %b, got %b", want.degen, got.degen);
          end
          if (got !== want) errors_o <= errors_o + 1;
        end
      end
    end
  end
endmodule

// File: tb/tb_triangle_unit_normal_unit.sv
// Testbench top: drives triangles into the normal pipeline and gives the verdict.
`timescale 1ns / 1ps
module tb_triangle_unit_normal_unit import tun_pkg::*;;
  localparam int unsigned CW = COORD_WIDTH_DEF;
  localparam int unsigned IW = ((9 * CW + 7) / 8) * 8;
  localparam int unsigned OW = ((3 * (OUT_FRAC_BITS_DEF + 2) + 7) / 8) * 8;
  localparam int NUM_RANDOM = 900;
  localparam int STALL_LIMIT = 3000;
  localparam int CMAX = (1 << (CW - 1)) - 1;
  localparam int CMIN = -(1 << (CW - 1));

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [IW-1:0] s_axis_tdata = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [OW-1:0] m_axis_tdata;
  logic [0:0]    m_axis_tuser;
  int            errors;
  int            pending;
  int            sent = 0;
  int            idle_cycles = 0;
  bit            steady = 1'b0;
  bit            hold_done = 1'b0;

  always #5 clk_i = ~clk_i;

  triangle_unit_normal_unit dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  tun_normal_scoreboard sb (
    .clk_i, .rst_ni,
    .pts_valid_i(s_axis_tvalid), .pts_ready_i(s_axis_tready), .pts_data_i(s_axis_tdata),
    .nrm_valid_i(m_axis_tvalid), .nrm_ready_i(m_axis_tready), .nrm_data_i(m_axis_tdata),
    .nrm_user_i(m_axis_tuser), .errors_o(errors), .pending_o(pending)
  );

  task automatic send_triangle(int c[9]);
    while (!steady && $urandom_range(99) < 17) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    for (int i = 0; i < 9; i++) s_axis_tdata[i*CW +: CW] = CW'(c[i]);
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
    @(negedge clk_i);
  endtask

  function automatic int rand_coord(int span);
    if (span >= CW) return int'(signed'(CW'($urandom)));
    return $urandom_range((1 << span) - 1) - (1 << (span - 1));
  endfunction

  // Receiver: random stalls, a stretch with no stalls, and one long hold-off.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && sent >= 600) begin
        hold_done = 1'b1;
        m_axis_tready = 1'b0;
        repeat (300) @(negedge clk_i);
      end
      m_axis_tready = steady || $urandom_range(99) >= 17;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    int c[9];
    int k;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    // Coincident points, all zero and all at the extremes.
    c = '{default: 0}; send_triangle(c);
    c = '{default: CMAX}; send_triangle(c);
    c = '{default: CMIN}; send_triangle(c);
    // Axis-aligned triangles facing each direction.
    c = '{256, 0, 0, 0, 0, 0, 0, 256, 0}; send_triangle(c);
    c = '{0, 256, 0, 0, 0, 0, 256, 0, 0}; send_triangle(c);
    c = '{0, 256, 0, 0, 0, 0, 0, 0, 256}; send_triangle(c);
    c = '{0, 0, 256, 0, 0, 0, 0, 256, 0}; send_triangle(c);
    c = '{0, 0, 256, 0, 0, 0, 256, 0, 0}; send_triangle(c);
    c = '{256, 0, 0, 0, 0, 0, 0, 0, 256}; send_triangle(c);
    // Largest spans, giving the widest cross product.
    c = '{CMAX, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMAX, CMIN}; send_triangle(c);
    c = '{CMIN, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMIN, CMAX}; send_triangle(c);
    c = '{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN}; send_triangle(c);
    c = '{CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX}; send_triangle(c);
    // Collinear points, the smallest nonzero area and a small general triangle.
    c = '{1, 1, 1, 0, 0, 0, 2, 2, 2}; send_triangle(c);
    c = '{CMAX, CMAX, CMAX, 0, 0, 0, CMIN + 1, CMIN + 1, CMIN + 1}; send_triangle(c);
    c = '{1, 0, 0, 0, 0, 0, 0, 1, 0}; send_triangle(c);
    c = '{-1, 0, 0, 0, 0, 0, 0, 0, -1}; send_triangle(c);
    c = '{3, 7, -5, 1, 1, 1, -2, 9, 4}; send_triangle(c);
    for (int n = 0; n < NUM_RANDOM; n++) begin
      steady = (n >= 300 && n < 450);
      k = $urandom_range(9);
      if (k < 5) begin
        for (int i = 0; i < 9; i++) c[i] = rand_coord(CW);
      end else if (k < 8) begin
        for (int i = 0; i < 9; i++) c[i] = rand_coord($urandom_range(12, 2));
      end else if (k == 8) begin
        for (int i = 0; i < 6; i++) c[i] = rand_coord(16);
        k = rand_coord(4);
        for (int i = 0; i < 3; i++) c[6+i] = c[3+i] + k * (c[i] - c[3+i]);
      end else begin
        for (int i = 0; i < 3; i++) c[i] = rand_coord(CW);
        for (int i = 3; i < 9; i++) c[i] = c[i%3];
        if ($urandom_range(1)) c[6] = c[6] ^ 1;
      end
      send_triangle(c);
    end
    steady = 1'b0;
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// File: filelist.f
hdl/tun_pkg.sv
hdl/tun_cross.sv
hdl/tun_square.sv
hdl/tun_sqrt.sv
hdl/tun_div.sv
hdl/triangle_unit_normal_unit.sv
tb/tun_normal_scoreboard.sv
tb/tb_triangle_unit_normal_unit.sv
